// ===== design/jls_pkg.sv =====
// Package for the Jacobi linear solver: sizes, payload structs, opcodes,
// register addresses and fixed-point helpers. Depends on nothing.
package jls_pkg;

    localparam int MATRIX_SIZE = 16;
    localparam int IDX_W       = $clog2(MATRIX_SIZE);
    localparam int COEF_DEPTH  = MATRIX_SIZE * MATRIX_SIZE;
    localparam int COEF_AW     = $clog2(COEF_DEPTH);
    localparam int SIZE_W      = 5;
    localparam int SWEEP_W     = 16;
    localparam int ADDR_W      = 3;

    localparam logic [1:0] OP_LOAD_COEF = 2'd0;
    localparam logic [1:0] OP_LOAD_RHS  = 2'd1;
    localparam logic [1:0] OP_START     = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_SIZE  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_SWEEP = 3'd4;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [31:0] S32_MAX = {1'b0, {31{1'b1}}};
    localparam logic signed [31:0] S32_MIN = {1'b1, {31{1'b0}}};

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         row;
        logic [3:0]         column;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] solution;
        logic               last;
        logic               divide_error;
    } t_out_word;

    // Divider request and reply between sequencer and divide unit
    typedef struct packed {
        logic               start;
        logic signed [63:0] num;
        logic signed [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;

    // Saturating 64-bit add
    function automatic logic signed [63:0] sat_add64(logic signed [63:0] a,
                                                      logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    // Saturating 64-bit subtract
    function automatic logic signed [63:0] sat_sub64(logic signed [63:0] a,
                                                      logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
            return a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

endpackage

// ===== design/jls_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module jls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read
    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/jls_div.sv =====
// Restoring divider: 64-bit signed numerator by 32-bit signed divisor,
// one quotient bit a cycle, truncated toward zero and saturated to 32 bits.
// Depends on jls_pkg.
module jls_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jls_pkg::t_div_req i_req,
    output jls_pkg::t_div_rsp o_rsp
);
    import jls_pkg::*;

    logic        r_busy, n_busy;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic signed [31:0] r_res, n_res;

    logic [63:0] num_mag;
    logic [31:0] den_mag;
    logic [32:0] trial;
    logic [32:0] shifted;
    logic [64:0] q_signed;

    assign num_mag = i_req.num[63] ? (~i_req.num + 64'd1) : i_req.num;
    assign den_mag = i_req.den[31] ? (~i_req.den + 32'd1) : i_req.den;
    assign shifted = {r_rem[31:0], r_quo[63]};
    assign trial   = shifted - {1'b0, r_den};
    assign q_signed = r_neg ? (~{1'b0, r_quo} + 65'd1) : {1'b0, r_quo};

    // Shift one bit per cycle, then sign and saturate
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_done = 1'b0;
        n_res  = r_res;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 7'd0;
            n_quo  = num_mag;
            n_rem  = 33'd0;
            n_den  = den_mag;
            n_neg  = i_req.num[63] ^ i_req.den[31];
        end else if (r_busy) begin
            if (r_cnt == 7'd64) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (!r_neg && r_quo > 64'h0000_0000_7FFF_FFFF)
                    n_res = S32_MAX;
                else if (r_neg && r_quo > 64'h0000_0000_8000_0000)
                    n_res = S32_MIN;
                else
                    n_res = q_signed[31:0];
            end else begin
                n_cnt = r_cnt + 7'd1;
                if (!trial[32]) begin
                    n_rem = trial;
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = shifted;
                    n_quo = {r_quo[62:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
        r_res <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_res;

endmodule

// ===== design/jacobi_linear_solver_unit.sv =====
// Jacobi linear solver, top level: APB registers, sequencer, shared MAC,
// coefficient and right-hand RAMs, divider. Depends on jls_pkg, jls_ram, jls_div.
// A solve runs the set number of sweeps over n rows, then emits n result words;
// the shared multiply-accumulate and the bit-serial divider serve every row.
// Loads write straight into the RAMs. One word at a time: busy stays high through a solve.
// Reset (synchronous, active low) clears control, size to 16, sweeps to 500.
module jacobi_linear_solver_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  jls_pkg::t_in_word   i_word,
    output logic                o_strobe,
    output jls_pkg::t_out_word  o_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import jls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_RHS, S_ADDR, S_MUL, S_ACC, S_NUM, S_DIV,
        S_COPY, S_EMIT
    } t_state;

    t_state r_state;
    logic [SIZE_W-1:0]  r_size;
    logic [SWEEP_W-1:0] r_sweeps;
    logic [SWEEP_W-1:0] r_sweep_cnt;
    logic [IDX_W-1:0]   r_i, r_j, r_n_m1;
    logic               r_err;
    logic signed [31:0] r_cur [MATRIX_SIZE];
    logic signed [31:0] r_nxt [MATRIX_SIZE];
    logic signed [63:0] r_acc;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_diag;
    logic signed [31:0] r_rhs;
    logic               r_diag_now;
    logic               r_strobe;
    t_out_word          r_out;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic        accept, cfg_wr;
    logic        coef_we, rhs_we;
    logic [31:0] coef_rd, rhs_rd;
    logic [COEF_AW-1:0] coef_raddr;
    logic [SIZE_W-1:0]  size_eff;
    logic signed [63:0] num_val;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == ADDR_SIZE)  ? {27'd0, r_size} :
                    (paddr == ADDR_SWEEP) ? {16'd0, r_sweeps} : 32'd0;

    assign coef_we = accept && (i_word.operation == OP_LOAD_COEF);
    assign rhs_we  = accept && (i_word.operation == OP_LOAD_RHS);
    assign coef_raddr = {r_i, r_j};

    // Clamp the size register to the legal range
    always_comb begin
        if (r_size == '0)
            size_eff = SIZE_W'(1);
        else if (r_size > SIZE_W'(MATRIX_SIZE))
            size_eff = SIZE_W'(MATRIX_SIZE);
        else
            size_eff = r_size;
    end

    assign num_val = sat_sub64({{16{r_rhs[31]}}, r_rhs, 16'd0}, r_acc);

    jls_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef (
        .i_clk  (i_clk),
        .i_we   (coef_we),
        .i_waddr({i_word.row, i_word.column}),
        .i_wdata(i_word.value),
        .i_raddr(coef_raddr),
        .o_rdata(coef_rd)
    );

    jls_ram #(.WIDTH(32), .DEPTH(MATRIX_SIZE)) u_rhs (
        .i_clk  (i_clk),
        .i_we   (rhs_we),
        .i_waddr(i_word.row),
        .i_wdata(i_word.value),
        .i_raddr(r_i),
        .o_rdata(rhs_rd)
    );

    assign div_req.start = (r_state == S_NUM) && (r_diag != '0);
    assign div_req.num   = num_val;
    assign div_req.den   = r_diag;

    jls_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // Sequencer: clear, then per row read b, walk columns, divide or saturate; then emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= SIZE_W'(16);
            r_sweeps    <= SWEEP_W'(500);
            r_strobe    <= 1'b0;
            r_err       <= 1'b0;
            r_sweep_cnt <= '0;
        end else begin
            r_strobe <= 1'b0;
            if (cfg_wr) begin
                if (paddr == ADDR_SIZE)
                    r_size <= pwdata[SIZE_W-1:0];
                else if (paddr == ADDR_SWEEP)
                    r_sweeps <= pwdata[SWEEP_W-1:0];
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_word.operation == OP_START) begin
                        r_n_m1      <= IDX_W'(size_eff - SIZE_W'(1));
                        r_err       <= 1'b0;
                        r_sweep_cnt <= '0;
                        r_i         <= '0;
                        r_state     <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    for (int k = 0; k < MATRIX_SIZE; k++)
                        r_cur[k] <= '0;
                    r_i     <= '0;
                    r_state <= (r_sweeps == '0) ? S_EMIT : S_RHS;
                end
                S_RHS: begin
                    r_j     <= '0;
                    r_acc   <= '0;
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    // RAM read of a[i][j] is in flight
                    r_diag_now <= (r_j == r_i);
                    r_state    <= S_MUL;
                end
                S_MUL: begin
                    r_rhs <= rhs_rd;
                    if (r_diag_now)
                        r_diag <= coef_rd;
                    r_prod  <= $signed(coef_rd) * r_cur[r_j];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (!r_diag_now)
                        r_acc <= sat_add64(r_acc, r_prod);
                    if (r_j == r_n_m1) begin
                        r_state <= S_NUM;
                    end else begin
                        r_j     <= r_j + IDX_W'(1);
                        r_state <= S_ADDR;
                    end
                end
                S_NUM: begin
                    if (r_diag == '0) begin
                        r_err        <= 1'b1;
                        r_nxt[r_i]   <= num_val[63] ? S32_MIN : S32_MAX;
                        r_state      <= S_COPY;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_nxt[r_i] <= div_rsp.quot;
                        r_state    <= S_COPY;
                    end
                end
                S_COPY: begin
                    if (r_i == r_n_m1) begin
                        for (int k = 0; k < MATRIX_SIZE; k++)
                            r_cur[k] <= (IDX_W'(k) == r_i) ? r_nxt[r_i] : r_nxt[k];
                        r_i <= '0;
                        if (r_sweep_cnt + SWEEP_W'(1) == r_sweeps) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_sweep_cnt <= r_sweep_cnt + SWEEP_W'(1);
                            r_state     <= S_RHS;
                        end
                    end else begin
                        r_i     <= r_i + IDX_W'(1);
                        r_state <= S_RHS;
                    end
                end
                S_EMIT: begin
                    r_strobe           <= 1'b1;
                    r_out.index        <= 4'(r_i);
                    r_out.solution     <= r_cur[r_i];
                    r_out.last         <= (r_i == r_n_m1);
                    r_out.divide_error <= r_err;
                    if (r_i == r_n_m1)
                        r_state <= S_IDLE;
                    else
                        r_i <= r_i + IDX_W'(1);
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_out;

    // Results appear only after the block has been busy
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy)) else $error("result without a solve");
    // The divider answers only while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV)) else $error("stray divider answer");
    // A last word ends the solve
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_word.last) |-> !busy) else $error("busy after last word");

endmodule
